/* rtl/wcc_pkg.sv */
// ----------------------------------------------------------------------------
// wcc_pkg - shared types and constants of the weak composition counter
// Modulus, count width and the wavefront beat passed between row cells.
// ----------------------------------------------------------------------------
package wcc_pkg;

    localparam int WAY_W = 30;
    localparam logic [WAY_W-1:0] WAY_MOD = 30'd1000000000;

    // one prefix-sum pass front moving along the cell row
    typedef struct packed {
        logic             tok;   // pass front present
        logic             last;  // final pass of the item
        logic [WAY_W-1:0] sum;   // running prefix sum of this pass
    } t_wave;

endpackage

/* rtl/wcc_cell.sv */
// ----------------------------------------------------------------------------
// wcc_cell - one column of the row store
// Holds one row entry; adds it to the passing prefix sum modulo 1e9.
// ----------------------------------------------------------------------------
module wcc_cell #(
    parameter int SW  = 8,
    parameter int IDX = 0
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_load,
    input  logic [SW-1:0]  i_thr,
    input  wcc_pkg::t_wave i_wave,
    output wcc_pkg::t_wave o_wave
);
    import wcc_pkg::*;

    logic [WAY_W-1:0] r_val;
    t_wave            r_wave;
    logic [WAY_W:0]   raw_sum;
    logic [WAY_W-1:0] mod_sum;

    always_comb begin
        raw_sum = {1'b0, i_wave.sum} + {1'b0, r_val};
        if (raw_sum >= {1'b0, WAY_MOD}) begin
            mod_sum = WAY_W'(raw_sum - {1'b0, WAY_MOD});
        end else begin
            mod_sum = raw_sum[WAY_W-1:0];
        end
    end

    // entry: ones from the threshold up, zero padding below it
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_val <= (SW'(IDX) >= i_thr) ? WAY_W'(1) : '0;
        end else if (i_wave.tok) begin
            r_val <= mod_sum;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wave <= '0;
        end else begin
            r_wave.tok  <= i_wave.tok;
            r_wave.last <= i_wave.last;
            r_wave.sum  <= mod_sum;
        end
    end

    assign o_wave = r_wave;

endmodule

/* rtl/weak_composition_counter.sv */
// ----------------------------------------------------------------------------
// weak_composition_counter - ordered splits of n into k parts, modulo 1e9
// Row of prefix-sum cells; passes travel the row as overlapping wavefronts.
// ----------------------------------------------------------------------------
//
//  channel  | dir | beat fields (tdata, low bit up)       | accepted when
//  ---------+-----+---------------------------------------+--------------------
//  s_axis   | in  | target_sum[7:0], part_count[15:8]     | tvalid && tready
//  m_axis   | out | way_count[29:0], zero pad [31:30]     | tvalid && tready
//
//  Sequence for k >= 2: a load state, then k-1 prefix passes launched from
//    the run state, then the last pass front crossing all MAX_SUM+1 cells.
//    k of 0 or 1 goes straight to the done state.
//  One item at a time; the next is taken once the result sits in the
//    output register, even while that result is still waiting downstream.
//  Reset clears control and the pass fronts; cell entries are reloaded by
//    every item before use.
//  A stalled output holds its beat; the block waits in its done state if
//    a new result is ready before the old one has left.
//
module weak_composition_counter #(
    parameter int MAX_SUM   = 255,
    parameter int MAX_PARTS = 255
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [15:0] i_s_axis_tdata,   // target_sum[7:0], part_count[15:8]
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [31:0] o_m_axis_tdata    // way_count[29:0], zeros[31:30]
);
    import wcc_pkg::*;

    localparam int SW = $clog2(MAX_SUM + 1);
    localparam int PW = $clog2(MAX_PARTS + 1);
    localparam int NC = MAX_SUM + 1;

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_LOAD  = 4'b0010,
        S_RUN   = 4'b0100,
        S_DONE  = 4'b1000
    } t_state;

    t_state            r_state, n_state;
    logic [SW-1:0]     r_thr, n_thr;
    logic [PW-1:0]     r_left, n_left;
    logic              r_drain, n_drain;     // passes launched, waiting for last
    logic [WAY_W-1:0]  r_res, n_res;
    t_wave             r_inj, n_inj;
    logic              r_ov, n_ov;
    logic [WAY_W-1:0]  r_out, n_out;

    logic [7:0]        in_n;
    logic [7:0]        in_k;
    logic [SW-1:0]     n_sat;
    logic [PW-1:0]     k_sat;
    logic              accept;
    logic              cell_load;
    t_wave             wave [NC+1];

    assign in_n   = i_s_axis_tdata[7:0];
    assign in_k   = i_s_axis_tdata[15:8];
    assign accept = i_s_axis_tvalid && o_s_axis_tready;

    // clamp to the row length and pass limit
    always_comb begin
        if (13'(in_n) > 13'(MAX_SUM)) begin
            n_sat = SW'(MAX_SUM);
        end else begin
            n_sat = SW'(in_n);
        end
        if (13'(in_k) > 13'(MAX_PARTS)) begin
            k_sat = PW'(MAX_PARTS);
        end else begin
            k_sat = PW'(in_k);
        end
    end

    assign cell_load = (r_state == S_LOAD);

    always_comb begin
        n_state  = r_state;
        n_thr    = r_thr;
        n_left   = r_left;
        n_drain  = r_drain;
        n_res    = r_res;
        n_inj    = '0;
        n_ov     = r_ov;
        n_out    = r_out;

        if (r_ov && i_m_axis_tready) begin
            n_ov = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (in_k == 8'd0) begin
                        // empty split exists only for a zero sum
                        n_res   = (in_n == 8'd0) ? WAY_W'(1) : '0;
                        n_state = S_DONE;
                    end else if (k_sat == PW'(1)) begin
                        // single part after the clamp: no prefix pass
                        n_res   = WAY_W'(1);
                        n_state = S_DONE;
                    end else begin
                        // right-align the row so entry n lands in the last cell
                        n_thr   = SW'(MAX_SUM) - n_sat;
                        n_left  = k_sat - PW'(1);
                        n_drain = 1'b0;
                        n_state = S_LOAD;
                    end
                end
            end
            S_LOAD: begin
                n_state = S_RUN;
            end
            S_RUN: begin
                if (!r_drain) begin
                    n_inj.tok  = 1'b1;
                    n_inj.last = (r_left == PW'(1));
                    n_left     = r_left - PW'(1);
                    if (r_left == PW'(1)) begin
                        n_drain = 1'b1;
                    end
                end
                if (wave[NC].tok && wave[NC].last) begin
                    n_res   = wave[NC].sum;
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (!r_ov || i_m_axis_tready) begin
                    n_ov    = 1'b1;
                    n_out   = r_res;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_drain <= 1'b0;
            r_inj   <= '0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_drain <= n_drain;
            r_inj   <= n_inj;
            r_ov    <= n_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        r_thr  <= n_thr;
        r_left <= n_left;
        r_res  <= n_res;
        r_out  <= n_out;
    end

    // cell row: cell c sees pass p in the cycle after cell c-1 did
    assign wave[0] = r_inj;

    for (genvar gi = 0; gi < NC; gi++) begin : g_cell
        wcc_cell #(
            .SW  (SW),
            .IDX (gi)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_load  (cell_load),
            .i_thr   (r_thr),
            .i_wave  (wave[gi]),
            .o_wave  (wave[gi+1])
        );
    end

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign o_m_axis_tvalid = r_ov;
    assign o_m_axis_tdata  = {2'b00, r_out};

    // no pass front may still be leaving the row's end once a new item can enter
    a_idle_row_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_s_axis_tready |-> !wave[NC].tok)
        else $error("pass front left on row while idle");

    // passes are launched only from the run state
    a_inject_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_inj.tok |-> $past(r_state == S_RUN))
        else $error("pass launched outside run state");

    // a finished result reaches the output once the register is free
    a_done_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && (!r_ov || i_m_axis_tready)) |=>
            (o_m_axis_tvalid && o_m_axis_tdata[29:0] == $past(r_res)))
        else $error("result not moved to output");

    // results stay reduced
    a_out_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> (o_m_axis_tdata[29:0] < WAY_MOD))
        else $error("result not reduced modulo 1e9");

endmodule
